// ===== hw/rtl/stt_pkg.sv =====
// Shared types, widths and register codes for the sparse triplet transpose block.
`default_nettype none
package stt_pkg;

  localparam int MAX_TERMS_DEF = 32;
  localparam int MAX_DIM_DEF   = 1024;

  localparam int DIM_W    = 11;
  localparam int IDX_W    = 10;
  localparam int VAL_W    = 32;
  localparam int COL_SPAN = 1 << IDX_W;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // register index, taken from paddr[2]
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
  } dims_t;

  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } term_t;

endpackage
`default_nettype wire

// ===== hw/rtl/stt_term_mem.sv =====
// Term store: one write port, one registered read port.
`default_nettype none
module stt_term_mem
  import stt_pkg::*;
#(
  parameter int MAX_TERMS = MAX_TERMS_DEF,
  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire term_t         wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output term_t              rd_data
);

  term_t mem [MAX_TERMS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/stt_cfg_regs.sv =====
// APB register file holding the source matrix dimensions.
`default_nettype none
module stt_cfg_regs
  import stt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready,
  output dims_t                  dims
);

  logic wr;
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims.rows <= DIM_W'(1);
      dims.cols <= DIM_W'(1);
    end else if (wr) begin
      case (paddr[2])
        REG_ROWS: dims.rows <= pwdata[DIM_W-1:0];
        REG_COLS: dims.cols <= pwdata[DIM_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ROWS: prdata = DATA_W'(dims.rows);
      REG_COLS: prdata = DATA_W'(dims.cols);
      default:  prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sparse_triplet_transpose.sv =====
// Sparse matrix transpose in triplet form: loader, column scanner and output stage.
// Load: one input word per cycle into the term store; no result until the last word.
// Transpose run: header first, then a read state and an evaluate state for each (column,
// stored term) pair, set by the single read port of the term store; output stalls add to the run.
// Input is stalled for the whole run. Reset (rst, synchronous) empties the store,
// clears the overflow mark and sets both dimensions to 1; no clearing pass is needed.
`default_nettype none
module sparse_triplet_transpose
  import stt_pkg::*;
#(
  parameter int MAX_TERMS = MAX_TERMS_DEF,
  parameter int MAX_DIM   = MAX_DIM_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                has_term,
  input  wire logic [IDX_W-1:0]    entry_row,
  input  wire logic [IDX_W-1:0]    entry_col,
  input  wire logic signed [VAL_W-1:0] entry_value,
  input  wire logic                entry_last,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     is_header,
  output logic [DIM_W-1:0]         out_row,
  output logic [DIM_W-1:0]         out_col,
  output logic signed [VAL_W-1:0]  out_value,
  output logic                     overflow,
  output logic                     out_last
);

  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam logic [31:0] MaxDimW = 32'(MAX_DIM);

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_HDR   = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_EV    = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  dims_t dims;

  stt_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .dims    (dims)
  );

  logic [2:0]       state;
  logic [CW-1:0]    count;
  logic             dropped;
  logic [AW-1:0]    j;
  logic [DIM_W-1:0] col;
  logic [DIM_W-1:0] col_limit;

  // result waiting for the next match (or the end of the scan) to learn its last mark
  logic                    held_hdr;
  logic [DIM_W-1:0]        held_row;
  logic [DIM_W-1:0]        held_col;
  logic signed [VAL_W-1:0] held_value;

  logic  in_acc;
  logic  mem_we;
  term_t wr_term;
  term_t rd_term;
  logic  rd_en;

  assign in_stall = (state != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign mem_we   = in_acc && has_term && (count < CW'(MAX_TERMS));
  assign rd_en    = (state == ST_RD);

  assign wr_term.row   = entry_row;
  assign wr_term.col   = entry_col;
  assign wr_term.value = entry_value;

  stt_term_mem #(.MAX_TERMS(MAX_TERMS)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (count[AW-1:0]),
    .wr_data (wr_term),
    .rd_en   (rd_en),
    .rd_addr (j),
    .rd_data (rd_term)
  );

  // saturate dimensions to MAX_DIM
  logic [DIM_W-1:0] rows_eff;
  logic [DIM_W-1:0] cols_eff;
  logic [DIM_W-1:0] scan_lim;

  always_comb begin
    rows_eff = ({21'b0, dims.rows} > MaxDimW) ? MaxDimW[DIM_W-1:0] : dims.rows;
    cols_eff = ({21'b0, dims.cols} > MaxDimW) ? MaxDimW[DIM_W-1:0] : dims.cols;
    scan_lim = (cols_eff > DIM_W'(COL_SPAN)) ? DIM_W'(COL_SPAN) : cols_eff;
  end

  logic          can_push;
  logic          match;
  logic          push;
  logic [CW-1:0] j_inc;
  logic          term_end;
  logic          col_end;

  assign can_push = !out_valid || !out_stall;
  assign match    = ({1'b0, rd_term.col} == col);
  assign push     = can_push && ((state == ST_EV && match) || state == ST_FLUSH);
  assign j_inc    = CW'(j) + CW'(1);
  assign term_end = (j_inc == count);
  assign col_end  = ((col + DIM_W'(1)) == col_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (has_term) begin
              if (mem_we) begin
                count <= count + CW'(1);
              end else begin
                dropped <= 1'b1;
              end
            end
            if (entry_last) begin
              state <= ST_HDR;
            end
          end
        end
        ST_HDR: begin
          if (count == '0 || scan_lim == '0) begin
            state <= ST_FLUSH;
          end else begin
            state <= ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_EV;
        end
        ST_EV: begin
          if (!match || can_push) begin
            if (term_end && col_end) begin
              state <= ST_FLUSH;
            end else begin
              state <= ST_RD;
            end
          end
        end
        ST_FLUSH: begin
          if (can_push) begin
            count   <= '0;
            dropped <= 1'b0;
            state   <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // scan counters, held result and output word
  always_ff @(posedge clk) begin
    case (state)
      ST_HDR: begin
        j          <= '0;
        col        <= '0;
        col_limit  <= scan_lim;
        held_hdr   <= 1'b1;
        held_row   <= cols_eff;
        held_col   <= rows_eff;
        held_value <= signed'(VAL_W'(count));
      end
      ST_EV: begin
        if (!match || can_push) begin
          if (match) begin
            is_header  <= held_hdr;
            out_row    <= held_row;
            out_col    <= held_col;
            out_value  <= held_value;
            overflow   <= dropped;
            out_last   <= 1'b0;
            held_hdr   <= 1'b0;
            held_row   <= {1'b0, rd_term.col};
            held_col   <= {1'b0, rd_term.row};
            held_value <= rd_term.value;
          end
          if (term_end) begin
            j   <= '0;
            col <= col + DIM_W'(1);
          end else begin
            j <= j_inc[AW-1:0];
          end
        end
      end
      ST_FLUSH: begin
        if (can_push) begin
          is_header <= held_hdr;
          out_row   <= held_row;
          out_col   <= held_col;
          out_value <= held_value;
          overflow  <= dropped;
          out_last  <= 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
